// ----- sv/rvdec_pkg.sv -----
// Shared types and constants of the RV32I decode stage.
package rvdec_pkg;

   // Register file geometry.
   localparam int XLEN       = 32;
   localparam int REG_COUNT  = 32;
   localparam int REG_ADDR_W = 5;

   // Major opcodes.
   localparam logic [6:0] OPC_LUI    = 7'b0110111;
   localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
   localparam logic [6:0] OPC_JAL    = 7'b1101111;
   localparam logic [6:0] OPC_JALR   = 7'b1100111;
   localparam logic [6:0] OPC_BRANCH = 7'b1100011;
   localparam logic [6:0] OPC_STORE  = 7'b0100011;
   localparam logic [6:0] OPC_LOAD   = 7'b0000011;
   localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
   localparam logic [6:0] OPC_OP     = 7'b0110011;

   // Execute operation codes.
   localparam logic [4:0] EX_ADD    = 5'd0;
   localparam logic [4:0] EX_SUB    = 5'd1;
   localparam logic [4:0] EX_SLL    = 5'd2;
   localparam logic [4:0] EX_SLT    = 5'd3;
   localparam logic [4:0] EX_SLTU   = 5'd4;
   localparam logic [4:0] EX_XOR    = 5'd5;
   localparam logic [4:0] EX_SRL    = 5'd6;
   localparam logic [4:0] EX_SRA    = 5'd7;
   localparam logic [4:0] EX_OR     = 5'd8;
   localparam logic [4:0] EX_AND    = 5'd9;
   localparam logic [4:0] EX_ADDI   = 5'd10;
   localparam logic [4:0] EX_SLTI   = 5'd11;
   localparam logic [4:0] EX_SLTIU  = 5'd12;
   localparam logic [4:0] EX_XORI   = 5'd13;
   localparam logic [4:0] EX_ORI    = 5'd14;
   localparam logic [4:0] EX_ANDI   = 5'd15;
   localparam logic [4:0] EX_SLLI   = 5'd16;
   localparam logic [4:0] EX_SRLI   = 5'd17;
   localparam logic [4:0] EX_SRAI   = 5'd18;
   localparam logic [4:0] EX_ADDPCI = 5'd19;
   localparam logic [4:0] EX_BEQ    = 5'd20;
   localparam logic [4:0] EX_BNE    = 5'd21;
   localparam logic [4:0] EX_BLT    = 5'd22;
   localparam logic [4:0] EX_BGE    = 5'd23;
   localparam logic [4:0] EX_BLTU   = 5'd24;
   localparam logic [4:0] EX_BGEU   = 5'd25;

   // Memory operation codes.
   localparam logic [3:0] MEM_PASS  = 4'd0;
   localparam logic [3:0] MEM_JUMP  = 4'd1;
   localparam logic [3:0] MEM_CJUMP = 4'd2;
   localparam logic [3:0] MEM_ST8   = 4'd3;
   localparam logic [3:0] MEM_ST16  = 4'd4;
   localparam logic [3:0] MEM_ST32  = 4'd5;
   localparam logic [3:0] MEM_LB    = 4'd6;
   localparam logic [3:0] MEM_LH    = 4'd7;
   localparam logic [3:0] MEM_LW    = 4'd8;
   localparam logic [3:0] MEM_LBU   = 4'd9;
   localparam logic [3:0] MEM_LHU   = 4'd10;

   // Write-back codes.
   localparam logic WB_WRITE = 1'b0;
   localparam logic WB_NONE  = 1'b1;

   // Register file write port.
   typedef struct packed {
      logic                  en;
      logic [REG_ADDR_W-1:0] addr;
      logic [XLEN-1:0]       data;
   } rf_write_type;

   // One decoded result.
   typedef struct packed {
      logic            wb_op;
      logic [3:0]      mem_op;
      logic [4:0]      exec_op;
      logic [XLEN-1:0] immediate;
      logic [XLEN-1:0] operand_b;
      logic [XLEN-1:0] operand_a;
   } bundle_type;

endpackage

// ----- sv/rvdec_ram.sv -----
// Generic RAM with one write port and two registered read ports.
module rvdec_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read ports; data holds while reads are not enabled.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= store_ff[rd_addr_a];
         rd_b_ff <= store_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- sv/rvdec_regfile.sv -----
// Register file: RAM storage, per-entry valid bits and same-cycle write bypass.
module rvdec_regfile (
   input  logic                               clock,
   input  logic                               reset,
   input  rvdec_pkg::rf_write_type            wr,
   input  logic                               rd_en,
   input  logic [rvdec_pkg::REG_ADDR_W-1:0]   rs1_addr,
   input  logic [rvdec_pkg::REG_ADDR_W-1:0]   rs2_addr,
   output logic [rvdec_pkg::XLEN-1:0]         rs1_data,
   output logic [rvdec_pkg::XLEN-1:0]         rs2_data
);

   logic                              wr_live;
   logic [rvdec_pkg::REG_COUNT-1:0]   valid_ff;
   logic [rvdec_pkg::REG_COUNT-1:0]   valid_in;
   logic                              v1_ff;
   logic                              v2_ff;
   logic                              hit1_ff;
   logic                              hit2_ff;
   logic [rvdec_pkg::XLEN-1:0]        byp_ff;
   logic [rvdec_pkg::XLEN-1:0]        ram_q1;
   logic [rvdec_pkg::XLEN-1:0]        ram_q2;

   // Register zero is never written, so it always reads as zero.
   assign wr_live = wr.en && (wr.addr != '0);

   rvdec_ram #(
      .WIDTH (rvdec_pkg::XLEN),
      .DEPTH (rvdec_pkg::REG_COUNT)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_live),
      .wr_addr   (wr.addr),
      .wr_data   (wr.data),
      .rd_en     (rd_en),
      .rd_addr_a (rs1_addr),
      .rd_addr_b (rs2_addr),
      .rd_data_a (ram_q1),
      .rd_data_b (ram_q2)
   );

   // An entry becomes valid once written; unwritten entries read as zero.
   always_comb begin
      valid_in = valid_ff;
      if (wr_live) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Read qualifiers, captured alongside the RAM read data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         hit1_ff <= 1'b0;
         hit2_ff <= 1'b0;
      end else if (rd_en) begin
         v1_ff   <= valid_ff[rs1_addr];
         v2_ff   <= valid_ff[rs2_addr];
         hit1_ff <= wr_live && (wr.addr == rs1_addr);
         hit2_ff <= wr_live && (wr.addr == rs2_addr);
      end
   end

   // Write data of the same transaction, forwarded past the RAM.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         byp_ff <= wr.data;
      end
   end

   assign rs1_data = hit1_ff ? byp_ff : (v1_ff ? ram_q1 : '0);
   assign rs2_data = hit2_ff ? byp_ff : (v2_ff ? ram_q2 : '0);

endmodule

// ----- sv/rvdec_decoder.sv -----
// Combinational RV32I instruction decoder producing one operand bundle.
module rvdec_decoder (
   input  logic [rvdec_pkg::XLEN-1:0] instruction,
   input  logic [rvdec_pkg::XLEN-1:0] pc,
   input  logic [rvdec_pkg::XLEN-1:0] rs1_data,
   input  logic [rvdec_pkg::XLEN-1:0] rs2_data,
   output rvdec_pkg::bundle_type      bundle
);

   logic [6:0]                  opc;
   logic [2:0]                  f3;
   logic                        alt;
   logic [rvdec_pkg::XLEN-1:0]  imm_i;
   logic [rvdec_pkg::XLEN-1:0]  imm_s;
   logic [rvdec_pkg::XLEN-1:0]  imm_b;
   logic [rvdec_pkg::XLEN-1:0]  imm_u;
   logic [rvdec_pkg::XLEN-1:0]  imm_j;
   logic [rvdec_pkg::XLEN-1:0]  link;

   assign opc = instruction[6:0];
   assign f3  = instruction[14:12];
   assign alt = instruction[30];

   // Immediate formats, all sign-extended from bit 31.
   assign imm_i = {{20{instruction[31]}}, instruction[31:20]};
   assign imm_s = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
   assign imm_b = {{19{instruction[31]}}, instruction[31], instruction[7],
                   instruction[30:25], instruction[11:8], 1'b0};
   assign imm_u = {instruction[31:12], 12'h000};
   assign imm_j = {{11{instruction[31]}}, instruction[31], instruction[19:12],
                   instruction[20], instruction[30:21], 1'b0};
   assign link  = pc + 32'd4;

   // Decode; anything unrecognised leaves the ADD x0, x0, x0 bundle.
   always_comb begin
      bundle.operand_a = '0;
      bundle.operand_b = '0;
      bundle.immediate = '0;
      bundle.exec_op   = rvdec_pkg::EX_ADD;
      bundle.mem_op    = rvdec_pkg::MEM_PASS;
      bundle.wb_op     = rvdec_pkg::WB_WRITE;
      case (opc)
         rvdec_pkg::OPC_LUI: begin
            bundle.immediate = imm_u;
            bundle.exec_op   = rvdec_pkg::EX_ADDI;
         end
         rvdec_pkg::OPC_AUIPC: begin
            bundle.immediate = imm_u;
            bundle.exec_op   = rvdec_pkg::EX_ADDPCI;
         end
         rvdec_pkg::OPC_JAL: begin
            bundle.immediate = imm_j;
            bundle.exec_op   = rvdec_pkg::EX_ADDPCI;
            bundle.operand_b = link;
            bundle.mem_op    = rvdec_pkg::MEM_JUMP;
         end
         rvdec_pkg::OPC_JALR: begin
            bundle.operand_a = rs1_data;
            bundle.immediate = imm_i;
            bundle.exec_op   = rvdec_pkg::EX_ADDI;
            bundle.operand_b = link;
            bundle.mem_op    = rvdec_pkg::MEM_JUMP;
         end
         rvdec_pkg::OPC_BRANCH: begin
            if (f3 != 3'd2 && f3 != 3'd3) begin
               bundle.operand_a = rs1_data;
               bundle.operand_b = rs2_data;
               bundle.immediate = imm_b;
               bundle.mem_op    = rvdec_pkg::MEM_CJUMP;
               bundle.wb_op     = rvdec_pkg::WB_NONE;
               case (f3)
                  3'd0:    bundle.exec_op = rvdec_pkg::EX_BEQ;
                  3'd1:    bundle.exec_op = rvdec_pkg::EX_BNE;
                  3'd4:    bundle.exec_op = rvdec_pkg::EX_BLT;
                  3'd5:    bundle.exec_op = rvdec_pkg::EX_BGE;
                  3'd6:    bundle.exec_op = rvdec_pkg::EX_BLTU;
                  default: bundle.exec_op = rvdec_pkg::EX_BGEU;
               endcase
            end
         end
         rvdec_pkg::OPC_STORE: begin
            if (f3 <= 3'd2) begin
               bundle.operand_a = rs1_data;
               bundle.immediate = imm_s;
               bundle.exec_op   = rvdec_pkg::EX_ADDI;
               bundle.wb_op     = rvdec_pkg::WB_NONE;
               case (f3)
                  3'd0: begin
                     bundle.operand_b = {24'h000000, rs2_data[7:0]};
                     bundle.mem_op    = rvdec_pkg::MEM_ST8;
                  end
                  3'd1: begin
                     bundle.operand_b = {16'h0000, rs2_data[15:0]};
                     bundle.mem_op    = rvdec_pkg::MEM_ST16;
                  end
                  default: begin
                     bundle.operand_b = rs2_data;
                     bundle.mem_op    = rvdec_pkg::MEM_ST32;
                  end
               endcase
            end
         end
         rvdec_pkg::OPC_LOAD: begin
            if (f3 != 3'd3 && f3 <= 3'd5) begin
               bundle.operand_a = rs1_data;
               bundle.immediate = imm_i;
               bundle.exec_op   = rvdec_pkg::EX_ADDI;
               case (f3)
                  3'd0:    bundle.mem_op = rvdec_pkg::MEM_LB;
                  3'd1:    bundle.mem_op = rvdec_pkg::MEM_LH;
                  3'd2:    bundle.mem_op = rvdec_pkg::MEM_LW;
                  3'd4:    bundle.mem_op = rvdec_pkg::MEM_LBU;
                  default: bundle.mem_op = rvdec_pkg::MEM_LHU;
               endcase
            end
         end
         rvdec_pkg::OPC_OPIMM: begin
            bundle.operand_a = rs1_data;
            bundle.immediate = imm_i;
            case (f3)
               3'd0:    bundle.exec_op = rvdec_pkg::EX_ADDI;
               3'd1:    bundle.exec_op = rvdec_pkg::EX_SLLI;
               3'd2:    bundle.exec_op = rvdec_pkg::EX_SLTI;
               3'd3:    bundle.exec_op = rvdec_pkg::EX_SLTIU;
               3'd4:    bundle.exec_op = rvdec_pkg::EX_XORI;
               3'd5:    bundle.exec_op = alt ? rvdec_pkg::EX_SRAI : rvdec_pkg::EX_SRLI;
               3'd6:    bundle.exec_op = rvdec_pkg::EX_ORI;
               default: bundle.exec_op = rvdec_pkg::EX_ANDI;
            endcase
         end
         rvdec_pkg::OPC_OP: begin
            bundle.operand_a = rs1_data;
            bundle.operand_b = rs2_data;
            case (f3)
               3'd0:    bundle.exec_op = alt ? rvdec_pkg::EX_SUB : rvdec_pkg::EX_ADD;
               3'd1:    bundle.exec_op = rvdec_pkg::EX_SLL;
               3'd2:    bundle.exec_op = rvdec_pkg::EX_SLT;
               3'd3:    bundle.exec_op = rvdec_pkg::EX_SLTU;
               3'd4:    bundle.exec_op = rvdec_pkg::EX_XOR;
               3'd5:    bundle.exec_op = alt ? rvdec_pkg::EX_SRA : rvdec_pkg::EX_SRL;
               3'd6:    bundle.exec_op = rvdec_pkg::EX_OR;
               default: bundle.exec_op = rvdec_pkg::EX_AND;
            endcase
         end
         default: begin
            bundle.exec_op = rvdec_pkg::EX_ADD;
         end
      endcase
   end

endmodule

// ----- sv/rv32i_decode_stage.sv -----
// Top level of the RV32I decode stage: input stage, register file, decoder, result register.
//
// Usage: each req transaction carries one instruction word, its pc and an
// optional register write-back. The write-back is applied to the register
// file first (register zero stays zero); the word is then decoded against
// the updated file and one rsp transaction carries operands A and B, the
// sign-extended immediate and the execute, memory and write-back codes.
// Path: on acceptance the input register and the registered read of the
// register file RAM are loaded together; the decoded result register is
// loaded from them after that, and the result is then offered.
// Throughput: one instruction per cycle while rsp_tready stays high, with a
// single decode pass and the RAM's one write and two read ports per cycle.
// Reset: synchronous; both pipeline stages empty, every register reads zero.
// Stall: while rsp_tready is low the result is held, the stage behind it
// still fills, and req_tready drops once both stages are full.
module rv32i_decode_stage (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // instruction[31:0], pc[63:32], write_enable[64], write_index[69:65],
   // write_data[101:70], zero[103:102]
   input  logic [103:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // operand_a[31:0], operand_b[63:32], immediate[95:64], exec_op[100:96],
   // mem_op[104:101], wb_op[105], zero[111:106]
   output logic [111:0]  rsp_tdata
);

   logic                        req_fire;
   logic                        s1_advance;
   logic                        rsp_free;
   logic                        s1_valid_ff;
   logic [31:0]                 s1_instr_ff;
   logic [31:0]                 s1_pc_ff;
   logic                        rsp_valid_ff;
   rvdec_pkg::bundle_type       rsp_bundle_ff;
   rvdec_pkg::bundle_type       dec_bundle;
   rvdec_pkg::rf_write_type     rf_wr;
   logic [31:0]                 rs1_data;
   logic [31:0]                 rs2_data;

   // Handshake: stages move forward whenever the one ahead is free.
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && rsp_free;
   assign req_tready = !s1_valid_ff || rsp_free;
   assign req_fire   = req_tvalid && req_tready;

   // Write-back port, driven only by an accepted transaction.
   assign rf_wr.en   = req_fire && req_tdata[64];
   assign rf_wr.addr = req_tdata[69:65];
   assign rf_wr.data = req_tdata[101:70];

   rvdec_regfile u_regfile (
      .clock    (clock),
      .reset    (reset),
      .wr       (rf_wr),
      .rd_en    (req_fire),
      .rs1_addr (req_tdata[19:15]),
      .rs2_addr (req_tdata[24:20]),
      .rs1_data (rs1_data),
      .rs2_data (rs2_data)
   );

   // Input stage control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   // Input stage payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_instr_ff <= req_tdata[31:0];
         s1_pc_ff    <= req_tdata[63:32];
      end
   end

   rvdec_decoder u_decoder (
      .instruction (s1_instr_ff),
      .pc          (s1_pc_ff),
      .rs1_data    (rs1_data),
      .rs2_data    (rs2_data),
      .bundle      (dec_bundle)
   );

   // Result register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_bundle_ff <= dec_bundle;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_bundle_ff};

endmodule

// ----- tb/tb_rv32i_decode_stage.sv -----
// Self-checking testbench for the RV32I decode stage: directed and random instruction streams.
module tb_rv32i_decode_stage;
   timeunit 1ns;
   timeprecision 1ps;

   // Opcodes that must decode to the NOP bundle.
   localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
   localparam logic [6:0] OPC_FENCE  = 7'b0001111;

   localparam int PHASES        = 5;
   localparam int RANDOM_ITEMS  = 1880;
   localparam int DRAIN_CYCLES  = 8;

   // One instruction with its optional register write-back.
   typedef struct {
      logic [31:0] word;
      logic [31:0] pc;
      logic        wr_en;
      logic [4:0]  wr_idx;
      logic [31:0] wr_data;
   } decode_req_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;

   decode_req_type         insn_q[$];
   rvdec_pkg::bundle_type  decoded_q[$];
   decode_req_type         in_flight;
   logic [31:0]  arch_regs [0:31];
   int           send_idle_pct  = 0;
   int           recv_stall_pct = 0;
   int           mismatch_count = 0;

   rv32i_decode_stage u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Builds a word from the R-type field layout; other formats reuse the same slots.
   function automatic logic [31:0] enc(input logic [6:0] f7, input logic [4:0] rs2,
                                       input logic [4:0] rs1, input logic [2:0] f3,
                                       input logic [4:0] rd, input logic [6:0] opc);
      return {f7, rs2, rs1, f3, rd, opc};
   endfunction

   // Expected decode of one word against the current register file.
   function automatic rvdec_pkg::bundle_type predict_bundle(input logic [31:0] w,
                                                            input logic [31:0] pc);
      rvdec_pkg::bundle_type o;
      logic [2:0]  f3;
      logic        alt;
      logic [31:0] r1, r2, imm_i, imm_s, imm_b, imm_j;
      f3    = w[14:12];
      alt   = w[30];
      r1    = arch_regs[w[19:15]];
      r2    = arch_regs[w[24:20]];
      imm_i = {{20{w[31]}}, w[31:20]};
      imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
      imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      // Start from the ADD x0, x0, x0 bundle.
      o           = '0;
      o.exec_op   = rvdec_pkg::EX_ADD;
      o.mem_op    = rvdec_pkg::MEM_PASS;
      o.wb_op     = rvdec_pkg::WB_WRITE;
      case (w[6:0])
         rvdec_pkg::OPC_LUI: begin
            o.immediate = {w[31:12], 12'b0};
            o.exec_op   = rvdec_pkg::EX_ADDI;
         end
         rvdec_pkg::OPC_AUIPC: begin
            o.immediate = {w[31:12], 12'b0};
            o.exec_op   = rvdec_pkg::EX_ADDPCI;
         end
         rvdec_pkg::OPC_JAL: begin
            o.immediate = imm_j;
            o.exec_op   = rvdec_pkg::EX_ADDPCI;
            o.operand_b = pc + 32'd4;
            o.mem_op    = rvdec_pkg::MEM_JUMP;
         end
         rvdec_pkg::OPC_JALR: begin
            o.operand_a = r1;
            o.immediate = imm_i;
            o.exec_op   = rvdec_pkg::EX_ADDI;
            o.operand_b = pc + 32'd4;
            o.mem_op    = rvdec_pkg::MEM_JUMP;
         end
         rvdec_pkg::OPC_BRANCH: begin
            if (f3 != 3'd2 && f3 != 3'd3) begin
               o.operand_a = r1;
               o.operand_b = r2;
               o.immediate = imm_b;
               o.mem_op    = rvdec_pkg::MEM_CJUMP;
               o.wb_op     = rvdec_pkg::WB_NONE;
               case (f3)
                  3'd0:    o.exec_op = rvdec_pkg::EX_BEQ;
                  3'd1:    o.exec_op = rvdec_pkg::EX_BNE;
                  3'd4:    o.exec_op = rvdec_pkg::EX_BLT;
                  3'd5:    o.exec_op = rvdec_pkg::EX_BGE;
                  3'd6:    o.exec_op = rvdec_pkg::EX_BLTU;
                  default: o.exec_op = rvdec_pkg::EX_BGEU;
               endcase
            end
         end
         rvdec_pkg::OPC_STORE: begin
            if (f3 <= 3'd2) begin
               o.operand_a = r1;
               o.immediate = imm_s;
               o.exec_op   = rvdec_pkg::EX_ADDI;
               o.wb_op     = rvdec_pkg::WB_NONE;
               case (f3)
                  3'd0: begin
                     o.operand_b = {24'b0, r2[7:0]};
                     o.mem_op    = rvdec_pkg::MEM_ST8;
                  end
                  3'd1: begin
                     o.operand_b = {16'b0, r2[15:0]};
                     o.mem_op    = rvdec_pkg::MEM_ST16;
                  end
                  default: begin
                     o.operand_b = r2;
                     o.mem_op    = rvdec_pkg::MEM_ST32;
                  end
               endcase
            end
         end
         rvdec_pkg::OPC_LOAD: begin
            if (f3 != 3'd3 && f3 <= 3'd5) begin
               o.operand_a = r1;
               o.immediate = imm_i;
               o.exec_op   = rvdec_pkg::EX_ADDI;
               case (f3)
                  3'd0:    o.mem_op = rvdec_pkg::MEM_LB;
                  3'd1:    o.mem_op = rvdec_pkg::MEM_LH;
                  3'd2:    o.mem_op = rvdec_pkg::MEM_LW;
                  3'd4:    o.mem_op = rvdec_pkg::MEM_LBU;
                  default: o.mem_op = rvdec_pkg::MEM_LHU;
               endcase
            end
         end
         rvdec_pkg::OPC_OPIMM: begin
            o.operand_a = r1;
            o.immediate = imm_i;
            case (f3)
               3'd0:    o.exec_op = rvdec_pkg::EX_ADDI;
               3'd1:    o.exec_op = rvdec_pkg::EX_SLLI;
               3'd2:    o.exec_op = rvdec_pkg::EX_SLTI;
               3'd3:    o.exec_op = rvdec_pkg::EX_SLTIU;
               3'd4:    o.exec_op = rvdec_pkg::EX_XORI;
               3'd5:    o.exec_op = alt ? rvdec_pkg::EX_SRAI : rvdec_pkg::EX_SRLI;
               3'd6:    o.exec_op = rvdec_pkg::EX_ORI;
               default: o.exec_op = rvdec_pkg::EX_ANDI;
            endcase
         end
         rvdec_pkg::OPC_OP: begin
            o.operand_a = r1;
            o.operand_b = r2;
            case (f3)
               3'd0:    o.exec_op = alt ? rvdec_pkg::EX_SUB : rvdec_pkg::EX_ADD;
               3'd1:    o.exec_op = rvdec_pkg::EX_SLL;
               3'd2:    o.exec_op = rvdec_pkg::EX_SLT;
               3'd3:    o.exec_op = rvdec_pkg::EX_SLTU;
               3'd4:    o.exec_op = rvdec_pkg::EX_XOR;
               3'd5:    o.exec_op = alt ? rvdec_pkg::EX_SRA : rvdec_pkg::EX_SRL;
               3'd6:    o.exec_op = rvdec_pkg::EX_OR;
               default: o.exec_op = rvdec_pkg::EX_AND;
            endcase
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic add_insn(input logic [31:0] word, input logic [31:0] pc,
                           input logic wr_en, input logic [4:0] wr_idx,
                           input logic [31:0] wr_data);
      decode_req_type r;
      r.word    = word;
      r.pc      = pc;
      r.wr_en   = wr_en;
      r.wr_idx  = wr_idx;
      r.wr_data = wr_data;
      insn_q.push_back(r);
   endtask

   function automatic logic [6:0] pick_opcode(input int k);
      case (k)
         0:       return rvdec_pkg::OPC_LUI;
         1:       return rvdec_pkg::OPC_AUIPC;
         2:       return rvdec_pkg::OPC_JAL;
         3:       return rvdec_pkg::OPC_JALR;
         4:       return rvdec_pkg::OPC_BRANCH;
         5:       return rvdec_pkg::OPC_STORE;
         6:       return rvdec_pkg::OPC_LOAD;
         7:       return rvdec_pkg::OPC_OPIMM;
         8:       return rvdec_pkg::OPC_OP;
         9:       return OPC_SYSTEM;
         default: return OPC_FENCE;
      endcase
   endfunction

   function automatic logic [31:0] pick_value();
      // Extremes now and then, otherwise anything.
      if ($urandom_range(7) == 0) begin
         case ($urandom_range(3))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      return $urandom();
   endfunction

   task automatic add_random_insn();
      logic [31:0] w;
      w = $urandom();
      // Mostly real opcodes with random fields, the rest arbitrary words.
      if ($urandom_range(99) < 90)
         w[6:0] = pick_opcode($urandom_range(10));
      add_insn(w, pick_value(), 1'($urandom_range(1)), 5'($urandom_range(31)),
               pick_value());
   endtask

   task automatic add_directed_insns();
      // Write-back applied before the read of the same transaction; x0 stays zero.
      add_insn(enc(7'h00, 5'd2, 5'd1, 3'd0, 5'd3, rvdec_pkg::OPC_OP), 32'h0, 1'b1, 5'd1,
               32'h7FFF_FFFF);
      add_insn(enc(7'h20, 5'd2, 5'd1, 3'd0, 5'd4, rvdec_pkg::OPC_OP), 32'hFFFF_FFFF, 1'b1,
               5'd2, 32'h8000_0000);
      add_insn(enc(7'h20, 5'd2, 5'd0, 3'd5, 5'd5, rvdec_pkg::OPC_OP), 32'h0, 1'b1, 5'd0,
               32'hFFFF_FFFF);
      // Funct7 bits other than bit 30 are ignored.
      add_insn(enc(7'h01, 5'd2, 5'd1, 3'd0, 5'd6, rvdec_pkg::OPC_OP), 32'h0, 1'b1, 5'd31,
               32'hFFFF_FFFF);
      // Stores of every width, and an unknown store width.
      add_insn(enc(7'h7F, 5'd31, 5'd31, 3'd0, 5'h1F, rvdec_pkg::OPC_STORE), 32'h0, 1'b0,
               5'd0, 32'h0);
      add_insn(enc(7'h40, 5'd31, 5'd2, 3'd1, 5'h00, rvdec_pkg::OPC_STORE), 32'h0, 1'b0,
               5'd0, 32'h0);
      add_insn(enc(7'h00, 5'd2, 5'd1, 3'd2, 5'h01, rvdec_pkg::OPC_STORE), 32'h0, 1'b0,
               5'd0, 32'h0);
      add_insn(enc(7'h7F, 5'd31, 5'd31, 3'd3, 5'h1F, rvdec_pkg::OPC_STORE), 32'h0, 1'b0,
               5'd0, 32'h0);
      // Branches with extreme offsets, and an unknown branch condition.
      add_insn(enc(7'h7F, 5'd2, 5'd1, 3'd0, 5'h1F, rvdec_pkg::OPC_BRANCH), 32'h0, 1'b0,
               5'd0, 32'h0);
      add_insn(enc(7'h3F, 5'd31, 5'd2, 3'd1, 5'h1E, rvdec_pkg::OPC_BRANCH), 32'h0, 1'b0,
               5'd0, 32'h0);
      add_insn(enc(7'h00, 5'd1, 5'd2, 3'd7, 5'h01, rvdec_pkg::OPC_BRANCH), 32'h0, 1'b0,
               5'd0, 32'h0);
      add_insn(enc(7'h7F, 5'd31, 5'd31, 3'd2, 5'h1F, rvdec_pkg::OPC_BRANCH), 32'h0, 1'b0,
               5'd0, 32'h0);
      // Loads: a valid one and two unknown widths.
      add_insn(enc(7'h7F, 5'd31, 5'd1, 3'd5, 5'd3, rvdec_pkg::OPC_LOAD), 32'h0, 1'b0,
               5'd0, 32'h0);
      add_insn(enc(7'h7F, 5'd31, 5'd1, 3'd3, 5'd3, rvdec_pkg::OPC_LOAD), 32'h0, 1'b0,
               5'd0, 32'h0);
      add_insn(enc(7'h7F, 5'd31, 5'd1, 3'd7, 5'd3, rvdec_pkg::OPC_LOAD), 32'h0, 1'b0,
               5'd0, 32'h0);
      // Shift immediates keep the whole 12-bit field.
      add_insn(enc(7'h20, 5'h1F, 5'd2, 3'd5, 5'd3, rvdec_pkg::OPC_OPIMM), 32'h0, 1'b0,
               5'd0, 32'h0);
      add_insn(enc(7'h40, 5'h05, 5'd31, 3'd1, 5'd3, rvdec_pkg::OPC_OPIMM), 32'h0, 1'b0,
               5'd0, 32'h0);
      // Upper immediates and jumps, with pc + 4 wrapping.
      add_insn({20'hFFFFF, 5'd1, rvdec_pkg::OPC_LUI}, 32'h0, 1'b0, 5'd0, 32'h0);
      add_insn({20'h80000, 5'd2, rvdec_pkg::OPC_AUIPC}, 32'h0, 1'b0, 5'd0, 32'h0);
      add_insn({1'b1, 10'h3FF, 1'b1, 8'hFF, 5'd1, rvdec_pkg::OPC_JAL}, 32'hFFFF_FFFC, 1'b0,
               5'd0, 32'h0);
      add_insn(enc(7'h7F, 5'd31, 5'd31, 3'd7, 5'd1, rvdec_pkg::OPC_JALR), 32'h7FFF_FFFC,
               1'b0, 5'd0, 32'h0);
      // ECALL, EBREAK, FENCE and an unknown opcode all give the NOP bundle.
      add_insn(32'h0000_0073, 32'h0, 1'b0, 5'd0, 32'h0);
      add_insn(32'h0010_0073, 32'h0, 1'b0, 5'd0, 32'h0);
      add_insn(32'h0FF0_000F, 32'h0, 1'b0, 5'd0, 32'h0);
      add_insn(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 5'd31, 32'h0);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // Driver: presents queued instructions and records the expected decode of each transaction.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (in_flight.wr_en && in_flight.wr_idx != 5'd0)
               arch_regs[in_flight.wr_idx] = in_flight.wr_data;
            decoded_q.push_back(predict_bundle(in_flight.word, in_flight.pc));
         end
         if (!req_tvalid || req_tready) begin
            if (insn_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               in_flight = insn_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {2'b00, in_flight.wr_data, in_flight.wr_idx, in_flight.wr_en,
                              in_flight.pc, in_flight.word};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks every result transaction against the oldest expectation.
   always @(posedge clock) begin
      rvdec_pkg::bundle_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[105:0];
            if (decoded_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end else begin
               want = decoded_q.pop_front();
               compare_field("operand_a", want.operand_a, got.operand_a);
               compare_field("operand_b", want.operand_b, got.operand_b);
               compare_field("immediate", want.immediate, got.immediate);
               compare_field("exec_op", {27'b0, want.exec_op}, {27'b0, got.exec_op});
               compare_field("mem_op", {28'b0, want.mem_op}, {28'b0, got.mem_op});
               compare_field("wb_op", {31'b0, want.wb_op}, {31'b0, got.wb_op});
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Stimulus: phases of differing back-pressure, each drained before the next starts.
   initial begin
      int send_pct [PHASES];
      int recv_pct [PHASES];
      send_pct = '{0, 78, 0, 26, 0};
      recv_pct = '{0, 0, 78, 26, 0};
      for (int i = 0; i < 32; i++)
         arch_regs[i] = 32'h0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < PHASES; p++) begin
         send_idle_pct  = send_pct[p];
         recv_stall_pct = recv_pct[p];
         if (p == 0)
            add_directed_insns();
         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
            add_random_insn();
         // Hold the sender back until every result of this phase is in.
         while (insn_q.size() != 0 || req_tvalid || decoded_q.size() != 0)
            @(posedge clock);
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Watchdog in case the handshake locks up.
   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
